FILE: hw/rtl/html_body_text_extractor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the body text extractor
// Both macros sample on i_clk and are switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HTML_BODY_TEXT_EXTRACTOR_ASSERT_SVH
`define HTML_BODY_TEXT_EXTRACTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hbte assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hbte assertion failed");

`endif

FILE: hw/rtl/hbte_pkg.sv
// ----------------------------------------------------------------------------
// hbte_pkg
// Shared constants, types and helper functions of the body text extractor.
// ----------------------------------------------------------------------------
package hbte_pkg;

    // Raw byte history used for marker matching.
    localparam int Window   = 9;
    localparam int WinIdxW  = $clog2(Window);
    localparam int PatMax   = 9;

    // Queue between the classifier and the output stage.
    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);
    localparam int QCntW    = QPtrW + 1;

    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;

    typedef logic [Window-1:0][7:0] t_win;
    typedef logic [8*PatMax-1:0]    t_pat;

    localparam t_pat PatBodyLo   = t_pat'("<body>");
    localparam t_pat PatBodyUp   = t_pat'("<BODY>");
    localparam t_pat PatBodySp   = t_pat'("<body ");
    localparam t_pat PatEndLo    = t_pat'("</body>");
    localparam t_pat PatEndUp    = t_pat'("</BODY>");
    localparam t_pat PatScrLo    = t_pat'("<script");
    localparam t_pat PatScrUp    = t_pat'("<SCRIPT");
    localparam t_pat PatScrEndLo = t_pat'("</script>");
    localparam t_pat PatScrEndUp = t_pat'("</SCRIPT>");

    // Fixed whitespace runs that replace layout tags.
    typedef enum logic [2:0] {
        RUN_TD,       // "   \t"
        RUN_TD_END,   // "    \t"
        RUN_BR,       // "  \r\n"
        RUN_BR_END,   // "   \r\n"
        RUN_P         // " \r\n"
    } t_run;

    typedef struct packed {
        logic       is_run;
        logic [7:0] data;
        t_run       run;
    } t_item;

    // True when the newest len bytes of the window equal the pattern.
    function automatic logic ends_with(input t_win w, input t_pat pat,
                                       input logic [3:0] len);
        logic               hit;
        logic [WinIdxW-1:0] widx;
        hit = 1'b1;
        for (int i = 0; i < PatMax; i++) begin
            widx = WinIdxW'(Window - int'(len) + i);
            if (i < int'(len)) begin
                if (w[widx] != pat[8*(int'(len)-1-i) +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    function automatic logic [2:0] run_len(input t_run run);
        logic [2:0] len;
        case (run)
            RUN_TD:     len = 3'd4;
            RUN_TD_END: len = 3'd5;
            RUN_BR:     len = 3'd4;
            RUN_BR_END: len = 3'd5;
            RUN_P:      len = 3'd3;
            default:    len = 3'd3;
        endcase
        return len;
    endfunction

    // Byte idx of a run: spaces, then a tab or a CR LF pair.
    function automatic logic [7:0] run_byte(input t_run run, input logic [2:0] idx);
        logic [2:0] len;
        logic       tab_tail;
        logic [7:0] b;
        len      = run_len(run);
        tab_tail = (run == RUN_TD) || (run == RUN_TD_END);
        if (tab_tail) begin
            b = (idx == len - 3'd1) ? ChTab : ChSpace;
        end else if (idx == len - 3'd1) begin
            b = ChLf;
        end else if (idx == len - 3'd2) begin
            b = ChCr;
        end else begin
            b = ChSpace;
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/hbte_front.sv
// ----------------------------------------------------------------------------
// hbte_front
// Accepts raw bytes, tracks the parse mode and pushes text bytes or
// replacement runs into the queue.
// ----------------------------------------------------------------------------
module hbte_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_doc_end,
    input  logic           i_full,
    output logic           o_push,
    output hbte_pkg::t_item o_item,
    output logic           o_searching
);
    import hbte_pkg::*;

    typedef enum logic [2:0] {
        M_SEARCH,
        M_TEXT,
        M_TAG,
        M_SCRIPT,
        M_DONE
    } t_mode;

    t_mode      r_mode, n_mode;
    t_win       r_win, n_win;
    logic [3:0] r_tag_len, n_tag_len;
    logic       r_ovf, n_ovf;
    logic       r_upper, n_upper;
    logic       w_accept;
    logic       w_body_end;

    assign o_ready     = !i_full;
    assign w_accept    = i_valid && !i_full;
    assign o_searching = (r_mode == M_SEARCH);

    always_comb begin
        n_win      = {i_in_byte, r_win[Window-1:1]};
        n_mode     = r_mode;
        n_tag_len  = r_tag_len;
        n_ovf      = r_ovf;
        n_upper    = r_upper;
        o_push     = 1'b0;
        o_item     = '{is_run: 1'b0, data: i_in_byte, run: RUN_P};
        w_body_end = ends_with(n_win, PatEndLo, 4'd7) || ends_with(n_win, PatEndUp, 4'd7);

        case (r_mode)
            M_SEARCH: begin
                if (ends_with(n_win, PatBodyLo, 4'd6) || ends_with(n_win, PatBodyUp, 4'd6)) begin
                    n_mode = M_TEXT;
                end else if (ends_with(n_win, PatBodySp, 4'd6)) begin
                    n_mode    = M_TAG;
                    n_tag_len = 4'd6;
                    n_ovf     = 1'b0;
                end
            end
            M_TEXT: begin
                if (w_body_end) begin
                    n_mode = M_DONE;
                end else if (i_in_byte == ChLt) begin
                    n_mode    = M_TAG;
                    n_tag_len = 4'd1;
                    n_ovf     = 1'b0;
                end else begin
                    o_push = w_accept;
                    if (i_in_byte == ChLf || i_in_byte == ChCr || i_in_byte == ChTab) begin
                        o_item.data = ChSpace;
                    end
                end
            end
            M_TAG: begin
                if (w_body_end) begin
                    n_mode = M_DONE;
                end else begin
                    // The length saturates at fifteen and then marks the tag as too long.
                    if (r_tag_len == 4'd15) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_tag_len = r_tag_len + 4'd1;
                    end
                    if (i_in_byte == ChGt) begin
                        n_mode = M_TEXT;
                        if (!n_ovf && n_tag_len == 4'd4) begin
                            o_item.is_run = 1'b1;
                            if (ends_with(n_win, t_pat'("<td>"), 4'd4) ||
                                ends_with(n_win, t_pat'("<TD>"), 4'd4)) begin
                                o_push     = w_accept;
                                o_item.run = RUN_TD;
                            end else if (ends_with(n_win, t_pat'("<th>"), 4'd4) ||
                                         ends_with(n_win, t_pat'("<TH>"), 4'd4) ||
                                         ends_with(n_win, t_pat'("<br>"), 4'd4) ||
                                         ends_with(n_win, t_pat'("<BR>"), 4'd4) ||
                                         ends_with(n_win, t_pat'("</p>"), 4'd4) ||
                                         ends_with(n_win, t_pat'("</P>"), 4'd4)) begin
                                o_push     = w_accept;
                                o_item.run = RUN_BR;
                            end
                        end else if (!n_ovf && n_tag_len == 4'd5) begin
                            o_item.is_run = 1'b1;
                            if (ends_with(n_win, t_pat'("</td>"), 4'd5) ||
                                ends_with(n_win, t_pat'("</TD>"), 4'd5)) begin
                                o_push     = w_accept;
                                o_item.run = RUN_TD_END;
                            end else if (ends_with(n_win, t_pat'("</th>"), 4'd5) ||
                                         ends_with(n_win, t_pat'("</TH>"), 4'd5) ||
                                         ends_with(n_win, t_pat'("</br>"), 4'd5) ||
                                         ends_with(n_win, t_pat'("</BR>"), 4'd5)) begin
                                o_push     = w_accept;
                                o_item.run = RUN_BR_END;
                            end
                        end else if (!n_ovf && n_tag_len == 4'd3) begin
                            o_item.is_run = 1'b1;
                            if (ends_with(n_win, t_pat'("<p>"), 4'd3) ||
                                ends_with(n_win, t_pat'("<P>"), 4'd3)) begin
                                o_push     = w_accept;
                                o_item.run = RUN_P;
                            end
                        end
                    end else if (!n_ovf && n_tag_len == 4'd7) begin
                        if (ends_with(n_win, PatScrLo, 4'd7)) begin
                            n_upper = 1'b0;
                            n_mode  = M_SCRIPT;
                        end else if (ends_with(n_win, PatScrUp, 4'd7)) begin
                            n_upper = 1'b1;
                            n_mode  = M_SCRIPT;
                        end
                    end
                end
            end
            M_SCRIPT: begin
                if (w_body_end) begin
                    n_mode = M_DONE;
                end else if (r_upper ? ends_with(n_win, PatScrEndUp, 4'd9)
                                     : ends_with(n_win, PatScrEndLo, 4'd9)) begin
                    n_mode = M_TEXT;
                end
            end
            M_DONE: begin
                n_mode = M_DONE;
            end
            default: begin
                n_mode = M_SEARCH;
            end
        endcase
    end

    // The last byte of a document returns everything to the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_doc_end)) begin
            r_mode    <= M_SEARCH;
            r_win     <= '0;
            r_tag_len <= 4'd0;
            r_ovf     <= 1'b0;
            r_upper   <= 1'b0;
        end else if (w_accept) begin
            r_mode    <= n_mode;
            r_win     <= n_win;
            r_tag_len <= n_tag_len;
            r_ovf     <= n_ovf;
            r_upper   <= n_upper;
        end
    end

endmodule

FILE: hw/rtl/hbte_fifo.sv
// ----------------------------------------------------------------------------
// hbte_fifo
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hbte_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hbte_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output hbte_pkg::t_item o_item
);
    import hbte_pkg::*;

    t_item             r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr, r_rd;
    logic [QCntW-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCntW'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCntW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCntW'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/hbte_back.sv
// ----------------------------------------------------------------------------
// hbte_back
// Takes items from the queue and drives the output register, expanding a
// replacement run into its bytes one per cycle while the output register is empty or being taken.
// ----------------------------------------------------------------------------
module hbte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  hbte_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_busy
);
    import hbte_pkg::*;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_bstate;

    t_bstate    r_state;
    t_run       r_run;
    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;

    // The output register may be refilled when empty or being taken.
    assign w_load     = !r_valid || i_ready;
    assign o_pop      = w_load && (r_state == B_IDLE) && !i_empty;
    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_last;
    assign o_busy     = (r_state == B_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (w_load) begin
            case (r_state)
                B_RUN: begin
                    r_valid <= 1'b1;
                    r_byte  <= run_byte(r_run, r_idx);
                    r_last  <= (r_idx == run_len(r_run) - 3'd1);
                    r_idx   <= r_idx + 3'd1;
                    if (r_idx == run_len(r_run) - 3'd1) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_empty) begin
                        r_valid <= 1'b0;
                    end else if (i_item.is_run) begin
                        // Every run has at least three bytes, so the first is never last.
                        r_valid <= 1'b1;
                        r_byte  <= run_byte(i_item.run, 3'd0);
                        r_last  <= 1'b0;
                        r_run   <= i_item.run;
                        r_idx   <= 3'd1;
                        r_state <= B_RUN;
                    end else begin
                        r_valid <= 1'b1;
                        r_byte  <= i_item.data;
                        r_last  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/html_body_text_extractor.sv
// ----------------------------------------------------------------------------
// html_body_text_extractor
// Extracts the plain text of an HTML body from a byte stream.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_in_byte, i_doc_end
//   output    out        o_valid / i_ready   o_out_byte, o_run_last
//
// One input byte is taken per cycle while the queue has room. A text byte
// passes through the queue into the output register; a replacement run of
// three to five bytes occupies the output register one byte at a time, and
// the four-entry queue absorbs input meanwhile. Reset is synchronous and
// active low; the last byte of a document clears the parser as reset does.
// ----------------------------------------------------------------------------
`include "html_body_text_extractor_assert.svh"

module html_body_text_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_doc_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import hbte_pkg::*;

    t_item w_push_item, w_pop_item;
    logic  w_push, w_pop, w_full, w_empty, w_searching, w_busy;

    hbte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_doc_end   (i_doc_end),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item),
        .o_searching (w_searching)
    );

    hbte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    hbte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_item     (w_pop_item),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_busy     (w_busy)
    );

    `HBTE_ASSERT_SAME(a_push_room, w_push, !w_full)
    `HBTE_ASSERT_SAME(a_pop_data, w_pop, !w_empty)
    `HBTE_ASSERT_NEXT(a_doc_end_clears, i_valid && o_ready && i_doc_end, w_searching)
    `HBTE_ASSERT_SAME(a_run_continues, o_valid && !o_run_last, w_busy)

endmodule
